>>> hdl/fxa_pkg.sv
// Package for the Q24.8 fixed-point ALU: word types, opcodes, status codes.
// No dependencies.
package fxa_pkg;
  localparam int FracBits = 8;
  localparam int QuoBits  = 32 + FracBits + 1;   // quotient magnitude bits
  localparam int NumCells = QuoBits;             // one restoring step per cell

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_SAT = 2'd1, ST_DIVZ = 2'd2
  } stat_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;
  } out_word_t;

  // Data handed from cell to cell.
  typedef struct packed {
    logic                 vld;
    logic                 is_div;
    logic                 neg;
    logic [QuoBits-1:0]   num;   // numerator bits still to shift in (MSB first)
    logic [QuoBits:0]     rem;   // partial remainder
    logic [QuoBits-1:0]   quo;   // quotient so far
    logic [32:0]          den;   // divisor magnitude
    out_word_t            pre;   // result for non-divide operations
  } cell_word_t;

  // Clamp a signed magnitude to 32 bits.
  function automatic out_word_t sat_mag(input logic [63:0] m, input logic neg);
    out_word_t o;
    o.compare_true = 1'b0;
    o.status       = ST_OK;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        o.result_value = 32'sh8000_0000;
        o.status = ST_SAT;
      end else begin
        o.result_value = 32'(-m);
      end
    end else if (m > 64'h7FFF_FFFF) begin
      o.result_value = 32'sh7FFF_FFFF;
      o.status = ST_SAT;
    end else begin
      o.result_value = m[31:0];
    end
    return o;
  endfunction
endpackage

>>> hdl/fixed_point_q24_8_alu_unit.sv
// Q24.8 fixed-point ALU: add, sub, mul, div, compares, min/max, inc/dec and
// integer conversions on 32-bit raw words, saturating and flagging overflow.
// Depends on fxa_pkg, fxa_front and fxa_cell.
//
// A word is taken at every clock edge where start is high; busy stays low, so
// one word enters per cycle. Every result leaves on out_* for one cycle marked
// by out_strobe, in order. It passes one front stage (all simple operations
// and the multiply), a chain of 41 restoring-division cells (one quotient
// bit each, 32 integer plus 8 fraction plus one rounding bit), and one
// output register that rounds and saturates.
// Every operation runs the same chain so results never reorder. The receiver
// cannot stall.
module fixed_point_q24_8_alu_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fxa_pkg::in_word_t   in_word,
  output logic                out_strobe,
  output fxa_pkg::out_word_t  out_word
);
  import fxa_pkg::*;

  cell_word_t chain [NumCells+1];
  logic [QuoBits-1:0] q_rnd;
  out_word_t o_nxt, o_r;
  logic      vld_r;

  assign busy = 1'b0;

  fxa_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(start && !busy), .in_w(in_word),
    .d_out(chain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    fxa_cell u_cell (.clk(clk), .rst_n(rst_n), .d_in(chain[i]), .d_out(chain[i+1]));
  end

  // Quotient carries one extra fraction bit: add it and drop it to round
  // half away from zero on the magnitude.
  always_comb begin
    q_rnd = (chain[NumCells].quo >> 1) + QuoBits'(chain[NumCells].quo[0]);
    if (chain[NumCells].is_div) begin
      o_nxt = sat_mag(64'(q_rnd), chain[NumCells].neg);
    end else begin
      o_nxt = chain[NumCells].pre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= chain[NumCells].vld;
    end
    o_r <= o_nxt;
  end

  assign out_strobe = vld_r;
  assign out_word   = o_r;

  // Strobe follows a valid word at the chain end through the output register.
  a_strobe_follows_cell: assert property (@(posedge clk) disable iff (!rst_n)
    chain[NumCells].vld |=> out_strobe) else $error("strobe lost at chain end");
  a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> chain[0].vld) else $error("accepted word not in front stage");
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.compare_true) |-> (out_word.result_value == 0 &&
     out_word.status == ST_OK)) else $error("compare result not clean");
endmodule

>>> hdl/fxa_cell.sv
// One restoring division step; carries the pipeline word to the next cell.
// Depends on fxa_pkg.
module fxa_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  fxa_pkg::cell_word_t d_in,
  output fxa_pkg::cell_word_t d_out
);
  import fxa_pkg::*;

  logic [QuoBits:0]   trial;
  logic [QuoBits+1:0] diff;
  cell_word_t         w_nxt;
  cell_word_t         w_r;

  always_comb begin
    w_nxt = d_in;
    // shift in next numerator bit, subtract divisor if it fits
    trial = {d_in.rem[QuoBits-1:0], d_in.num[QuoBits-1]};
    diff  = {1'b0, trial} - {{(QuoBits-31){1'b0}}, d_in.den};
    w_nxt.num = {d_in.num[QuoBits-2:0], 1'b0};
    if (!diff[QuoBits+1]) begin
      w_nxt.rem = diff[QuoBits:0];
      w_nxt.quo = {d_in.quo[QuoBits-2:0], 1'b1};
    end else begin
      w_nxt.rem = trial;
      w_nxt.quo = {d_in.quo[QuoBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.vld <= 1'b0;
    end else begin
      w_r.vld <= d_in.vld;
    end
    w_r.is_div <= w_nxt.is_div;
    w_r.neg    <= w_nxt.neg;
    w_r.num    <= w_nxt.num;
    w_r.rem    <= w_nxt.rem;
    w_r.quo    <= w_nxt.quo;
    w_r.den    <= w_nxt.den;
    w_r.pre    <= w_nxt.pre;
  end

  assign d_out = w_r;
endmodule

>>> hdl/fxa_front.sv
// Front stage: decodes the opcode, does all simple operations and
// the multiply, and loads the divide word. Depends on fxa_pkg.
module fxa_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  fxa_pkg::in_word_t  in_w,
  output fxa_pkg::cell_word_t d_out
);
  import fxa_pkg::*;

  logic signed [32:0] a_x, b_x, b_sel;
  logic signed [33:0] sum, dif;
  logic signed [63:0] prod;
  logic [63:0]        pmag;
  logic [63:0]        mrnd;
  logic [31:0]        amag;
  logic signed [63:0] fint;
  logic               gt, eq;
  out_word_t          o;
  cell_word_t         w_nxt, w_r;

  always_comb begin
    a_x  = 33'(in_w.operand_a);
    b_x  = 33'(in_w.operand_b);
    // inc and dec step by one raw LSB instead of operand_b
    b_sel = ((op_t'(in_w.mode) == OP_INC) || (op_t'(in_w.mode) == OP_DEC)) ?
            33'sd1 : b_x;
    sum  = 34'(a_x) + 34'(b_sel);
    dif  = 34'(a_x) - 34'(b_sel);
    prod = 64'(in_w.operand_a) * 64'(in_w.operand_b);
    pmag = prod[63] ? 64'(-prod) : prod;
    mrnd = (pmag + (64'd1 << FracBits) / 64'd2) >> FracBits;
    amag = in_w.operand_a[31] ? 32'(-a_x) : 32'(a_x);
    fint = 64'(in_w.operand_a) <<< FracBits;
    gt   = in_w.operand_a > in_w.operand_b;
    eq   = in_w.operand_a == in_w.operand_b;
    o.result_value = '0;
    o.compare_true = 1'b0;
    o.status       = ST_OK;
    case (op_t'(in_w.mode))
      OP_ADD, OP_INC: o = sat_mag(
        sum[33] ? 64'(-64'(sum)) : 64'(sum), sum[33]);
      OP_SUB, OP_DEC: o = sat_mag(
        dif[33] ? 64'(-64'(dif)) : 64'(dif), dif[33]);
      OP_MUL:     o = sat_mag(mrnd, prod[63]);
      OP_DIV:     if (in_w.operand_b == 0) o.status = ST_DIVZ;
      OP_GT:      o.compare_true = gt;
      OP_LT:      o.compare_true = !gt && !eq;
      OP_GE:      o.compare_true = gt || eq;
      OP_LE:      o.compare_true = !gt;
      OP_EQ:      o.compare_true = eq;
      OP_NE:      o.compare_true = !eq;
      OP_MIN:     o.result_value = gt ? in_w.operand_b : in_w.operand_a;
      OP_MAX:     o.result_value = gt ? in_w.operand_a : in_w.operand_b;
      OP_TOINT:   o.result_value = in_w.operand_a >>> FracBits;
      default:    o = sat_mag(fint[63] ? 64'(-fint) : 64'(fint), fint[63]);
    endcase
    w_nxt.vld    = acc;
    w_nxt.is_div = (op_t'(in_w.mode) == OP_DIV) && (in_w.operand_b != 0);
    w_nxt.neg    = in_w.operand_a[31] ^ in_w.operand_b[31];
    // numerator n = |a|<<F carries one extra LSB for the half step: the cells
    // divide 2n by d and the output rounds, which gives (2n+d)/(2d)
    w_nxt.num    = {amag, {FracBits{1'b0}}, 1'b0};
    w_nxt.rem    = '0;
    w_nxt.quo    = '0;
    w_nxt.den    = in_w.operand_b[31] ? 33'(-b_x) : 33'(b_x);
    w_nxt.pre    = o;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.vld <= 1'b0;
    end else begin
      w_r.vld <= w_nxt.vld;
    end
    w_r.is_div <= w_nxt.is_div;
    w_r.neg    <= w_nxt.neg;
    w_r.num    <= w_nxt.num;
    w_r.rem    <= w_nxt.rem;
    w_r.quo    <= w_nxt.quo;
    w_r.den    <= w_nxt.den;
    w_r.pre    <= w_nxt.pre;
  end

  assign d_out = w_r;
endmodule

>>> bench/tb_fixed_point_q24_8_alu_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for the Q24.8 fixed-point ALU: random and directed words
// checked against an in-bench arithmetic predictor. Depends on fxa_pkg and DUT.
module tb_fixed_point_q24_8_alu_unit;
  import fxa_pkg::*;

  localparam int Latency  = 43;
  localparam int Watchdog = 2000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_word_t in_word;
  logic out_strobe;
  out_word_t out_word;

  in_word_t pending_words[$];
  out_word_t expected_results[$];
  int mismatch_count;
  int idle_pct;
  int quiet_cycles;
  bit timed_out;
  bit hold_sender;

  fixed_point_q24_8_alu_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_strobe(out_strobe), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp a 64-bit signed value to the raw 32-bit range.
  function automatic out_word_t clamp_raw(input longint v);
    out_word_t o;
    o = '0;
    if (v > 64'sd2147483647) begin
      o.result_value = 32'sh7FFF_FFFF;
      o.status = ST_SAT;
    end else if (v < -64'sd2147483648) begin
      o.result_value = 32'sh8000_0000;
      o.status = ST_SAT;
    end else begin
      o.result_value = v[31:0];
    end
    return o;
  endfunction

  // Compute the ALU result for one input word.
  function automatic out_word_t alu_result(input in_word_t w);
    out_word_t o;
    longint a, b, p;
    logic [127:0] n, d, q, m;
    a = w.operand_a;
    b = w.operand_b;
    o = '0;
    case (op_t'(w.mode))
      OP_ADD: o = clamp_raw(a + b);
      OP_SUB: o = clamp_raw(a - b);
      OP_MUL: begin
        p = a * b;
        m = (p < 0) ? 128'(-p) : 128'(p);
        m = (m + (FracBits > 0 ? (128'd1 << (FracBits - 1)) : 128'd0)) >> FracBits;
        o = clamp_raw((p < 0) ? -longint'(m) : longint'(m));
      end
      OP_DIV: begin
        if (b == 0) begin
          o.status = ST_DIVZ;
        end else begin
          n = ((a < 0) ? 128'(-a) : 128'(a)) << FracBits;
          d = (b < 0) ? 128'(-b) : 128'(b);
          q = (2 * n + d) / (2 * d);
          o = clamp_raw(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q));
        end
      end
      OP_GT: o.compare_true = a > b;
      OP_LT: o.compare_true = a < b;
      OP_GE: o.compare_true = a >= b;
      OP_LE: o.compare_true = a <= b;
      OP_EQ: o.compare_true = a == b;
      OP_NE: o.compare_true = a != b;
      OP_MIN: o.result_value = (a > b) ? w.operand_b : w.operand_a;
      OP_MAX: o.result_value = (a > b) ? w.operand_a : w.operand_b;
      OP_INC: o = clamp_raw(a + 1);
      OP_DEC: o = clamp_raw(a - 1);
      OP_TOINT: o.result_value = w.operand_a >>> FracBits;
      default: o = clamp_raw(a * (64'sd1 << FracBits));
    endcase
    return o;
  endfunction

  // Random operand biased toward edges, small magnitudes and full range.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 2048)) - 1024);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      4: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t make_word(input op_t op, input logic [31:0] a,
                                         input logic [31:0] b);
    in_word_t w;
    w.mode = op;
    w.operand_a = a;
    w.operand_b = b;
    return w;
  endfunction

  // Driver: offer the head of the queue, hold it until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(alu_result(in_word));
        void'(pending_words.pop_front());
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_words.size() > 0 && !hold_sender
                   && $urandom_range(0, 99) >= idle_pct) begin
        in_word <= pending_words[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed word must match the oldest expectation.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n) begin
      if ((start && !busy) || out_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result word %h", out_word);
        end else begin
          exp_w = expected_results.pop_front();
          if (out_word.result_value !== exp_w.result_value ||
              out_word.compare_true !== exp_w.compare_true ||
              out_word.status !== exp_w.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected val %h cmp %b st %0d, got val %h cmp %b st %0d",
                       exp_w.result_value, exp_w.compare_true, exp_w.status,
                       out_word.result_value, out_word.compare_true, out_word.status);
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n && quiet_cycles > Watchdog && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_fixed_point_q24_8_alu_unit: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    op_t op;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    mismatch_count = 0;
    quiet_cycles = 0;
    idle_pct = 10;
    hold_sender = 1'b0;
    timed_out = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every op at the extremes, plus divide by zero and rounding ties.
    for (int k = 0; k < 16; k++) begin
      op = op_t'(k);
      pending_words.push_back(make_word(op, 32'h7FFF_FFFF, 32'h8000_0000));
    end
    pending_words.push_back(make_word(OP_DIV, 32'h0000_0100, 32'h0));
    pending_words.push_back(make_word(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OP_MUL, 32'h0000_0001, 32'h0000_0080));
    pending_words.push_back(make_word(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080));
    pending_words.push_back(make_word(OP_DIV, 32'h0000_0001, 32'h0000_0200));
    pending_words.push_back(make_word(OP_INC, 32'h7FFF_FFFF, 32'h0));
    pending_words.push_back(make_word(OP_DEC, 32'h8000_0000, 32'h0));
    pending_words.push_back(make_word(OP_EQ, 32'h1234_5678, 32'h1234_5678));
    pending_words.push_back(make_word(OP_TOINT, 32'hFFFF_FF01, 32'h0));

    // Wait until every outstanding result is back, then hold the sender off.
    wait_drained();
    hold_sender = 1'b1;
    repeat (3) @(posedge clk);
    hold_sender = 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 10 : (phase == 1) ? 85 : 0;
      for (int k = 0; k < 550; k++) begin
        op = op_t'($urandom_range(0, 15));
        pending_words.push_back(make_word(op, pick_operand(), pick_operand()));
      end
      wait_drained();
    end

    repeat (Latency + 5) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("tb_fixed_point_q24_8_alu_unit: PASS");
    else
      $display("tb_fixed_point_q24_8_alu_unit: FAIL");
    $finish;
  end
endmodule
